// ===== hw/rtl/humidity_zone_classifier_assert.svh =====
`ifndef HUMIDITY_ZONE_CLASSIFIER_ASSERT_SVH
`define HUMIDITY_ZONE_CLASSIFIER_ASSERT_SVH

// Implication checked in the same cycle, masked while reset is active.
`define HZC_ASSERT_NOW(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("hzc assertion failed");

// Implication checked in the next cycle, masked while reset is active.
`define HZC_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("hzc assertion failed");

// Condition that must hold in the cycle after reset is sampled active.
`define HZC_ASSERT_RST(name, cons) \
  name: assert property (@(posedge clk) (!rst_n) |=> (cons)) \
    else $error("hzc assertion failed after reset");

`endif

// ===== hw/rtl/hzc_pkg.sv =====
package hzc_pkg;

  localparam int unsigned TEMP_W = 8;
  localparam int unsigned HUMI_W = 7;
  localparam int unsigned OFFS_W = 7;
  localparam int unsigned HYST_W = 4;
  localparam int unsigned FALL_W = 4;
  localparam int unsigned ZONE_W = 2;
  localparam int unsigned ROW_W  = 3;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 7;
  localparam int unsigned IN_TDATA_W  = 16;
  localparam int unsigned OUT_TDATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_IDX_OFFSET = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_HYST   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_FALL   = 2'd2;

  localparam logic [OFFS_W-1:0] OFFSET_RST = 7'd8;
  localparam logic [HYST_W-1:0] HYST_RST   = 4'd2;
  localparam logic [FALL_W-1:0] FALL_RST   = 4'd2;

  localparam logic [ZONE_W-1:0] ZONE_I   = 2'd0;
  localparam logic [ZONE_W-1:0] ZONE_II  = 2'd1;
  localparam logic [ZONE_W-1:0] ZONE_III = 2'd2;
  localparam logic [ZONE_W-1:0] ZONE_IV  = 2'd3;

  localparam logic [HUMI_W:0] HUMI_CLAMP = 8'd99;

  localparam logic signed [TEMP_W-1:0] TEMP_EDGE0 = 8'sd18;
  localparam logic signed [TEMP_W-1:0] TEMP_EDGE1 = 8'sd23;
  localparam logic signed [TEMP_W-1:0] TEMP_EDGE2 = 8'sd27;
  localparam logic signed [TEMP_W-1:0] TEMP_EDGE3 = 8'sd32;

  typedef struct packed {
    logic [OFFS_W-1:0] humidity_offset;
    logic [HYST_W-1:0] band_hysteresis;
    logic [FALL_W-1:0] fall_margin;
  } cfg_t;

  typedef struct packed {
    logic                     auto_enabled;
    logic [HUMI_W-1:0]        humidity;
    logic signed [TEMP_W-1:0] temperature;
  } in_item_t;

  typedef struct packed {
    logic              high_lock;
    logic [ZONE_W-1:0] zone;
  } out_item_t;

  typedef struct packed {
    logic [HUMI_W-1:0] hi;
    logic [HUMI_W-1:0] mid;
    logic [HUMI_W-1:0] lo;
  } thr_t;

  function automatic logic [ROW_W-1:0] pick_row(input logic signed [TEMP_W-1:0] t);
    logic [ROW_W-1:0] row;
    if (t < TEMP_EDGE0) begin
      row = 3'd0;
    end else if (t < TEMP_EDGE1) begin
      row = 3'd1;
    end else if (t < TEMP_EDGE2) begin
      row = 3'd2;
    end else if (t < TEMP_EDGE3) begin
      row = 3'd3;
    end else begin
      row = 3'd4;
    end
    return row;
  endfunction

  function automatic thr_t row_thresholds(input logic [ROW_W-1:0] row);
    thr_t thr;
    case (row)
      3'd0:    thr = '{hi: 7'd48, mid: 7'd45, lo: 7'd40};
      3'd1:    thr = '{hi: 7'd58, mid: 7'd55, lo: 7'd50};
      3'd2:    thr = '{hi: 7'd68, mid: 7'd65, lo: 7'd60};
      3'd3:    thr = '{hi: 7'd48, mid: 7'd45, lo: 7'd40};
      default: thr = '{hi: 7'd43, mid: 7'd40, lo: 7'd35};
    endcase
    return thr;
  endfunction

endpackage

// ===== hw/rtl/hzc_cfg.sv =====
module hzc_cfg
  import hzc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output cfg_t                  cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  assign cfg_ready = 1'b1;
  assign cfg = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        CFG_IDX_OFFSET: cfg_nxt.humidity_offset = cfg_data;
        CFG_IDX_HYST:   cfg_nxt.band_hysteresis = cfg_data[HYST_W-1:0];
        CFG_IDX_FALL:   cfg_nxt.fall_margin     = cfg_data[FALL_W-1:0];
        default:        cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{humidity_offset: OFFSET_RST, band_hysteresis: HYST_RST,
                 fall_margin: FALL_RST};
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

// ===== hw/rtl/hzc_core.sv =====
module hzc_core
  import hzc_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      step,
  input  in_item_t  item,
  input  cfg_t      cfg,
  output out_item_t res
);

  logic [ZONE_W-1:0] zone_r, zone_nxt;
  logic [HUMI_W-1:0] peak_r, peak_nxt;
  logic              lock_r, lock_nxt;

  logic [HUMI_W:0]   sum;
  logic [HUMI_W-1:0] fin;
  thr_t              thr;
  logic [HUMI_W:0]   hyst;
  logic [HUMI_W:0]   hi_up, mid_up, lo_up, lo_dn;
  logic [ZONE_W-1:0] calc;
  logic [HUMI_W-1:0] drop;

  always_comb begin
    sum  = {1'b0, item.humidity} + {1'b0, cfg.humidity_offset};
    fin  = (sum > HUMI_CLAMP) ? HUMI_CLAMP[HUMI_W-1:0] : sum[HUMI_W-1:0];
    thr  = row_thresholds(pick_row(item.temperature));
    hyst = {{(HUMI_W+1-HYST_W){1'b0}}, cfg.band_hysteresis};
    hi_up  = {1'b0, thr.hi}  + hyst;
    mid_up = {1'b0, thr.mid} + hyst;
    lo_up  = {1'b0, thr.lo}  + hyst;
    lo_dn  = {1'b0, thr.lo}  - hyst;
    drop   = (peak_r > fin) ? (peak_r - fin) : '0;

    zone_nxt = zone_r;
    peak_nxt = peak_r;
    lock_nxt = 1'b0;
    calc     = zone_r;

    if (item.auto_enabled) begin
      lock_nxt = lock_r;
      if ({1'b0, fin} >= hi_up) begin
        calc     = ZONE_IV;
        lock_nxt = 1'b1;
      end else if ({1'b0, fin} >= mid_up) begin
        calc = ZONE_III;
      end else if ({1'b0, fin} >= lo_up) begin
        calc = ZONE_II;
      end else if ({1'b0, fin} <= lo_dn) begin
        calc = ZONE_I;
      end

      if (lock_nxt && (calc < ZONE_III)) begin
        calc = ZONE_III;
      end

      if (calc > zone_r) begin
        zone_nxt = calc;
        peak_nxt = fin;
      end else if (calc == zone_r) begin
        if (fin > peak_r) begin
          peak_nxt = fin;
        end
      end else if (drop >= {{(HUMI_W-FALL_W){1'b0}}, cfg.fall_margin}) begin
        zone_nxt = calc;
        peak_nxt = fin;
      end
    end

    res = '{high_lock: lock_nxt, zone: zone_nxt};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      zone_r <= ZONE_I;
      peak_r <= '0;
      lock_r <= 1'b0;
    end else if (step) begin
      zone_r <= zone_nxt;
      peak_r <= peak_nxt;
      lock_r <= lock_nxt;
    end
  end

endmodule

// ===== hw/rtl/humidity_zone_classifier.sv =====
// Path: a result passes through the input register and then the output register on its
// way to the output, and is held back while the output is stalled.
// Throughput: one item per cycle while the output is not stalled; the zone state is updated
// when an item moves from the input register to the output register.
// Reset: synchronous active-low rst_n empties both registers, sets zone I with
// zero peak and no lock, and loads the register defaults.
module humidity_zone_classifier
  import hzc_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // temperature[7:0], humidity[14:8], auto_enabled[15]
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // zone[1:0], high_lock[2], zero padding[7:3]
  output logic [OUT_TDATA_W-1:0] out_tdata,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  cfg_t      cfg;
  in_item_t  item_r;
  logic      item_valid_r;
  out_item_t res;
  out_item_t res_r;
  logic      out_valid_r;
  logic      out_free;
  logic      step;

  assign out_free  = !out_valid_r || out_tready;
  assign step      = item_valid_r && out_free;
  assign in_tready = !item_valid_r || out_free;

  hzc_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  hzc_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (step),
    .item  (item_r),
    .cfg   (cfg),
    .res   (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (in_tready) begin
        item_valid_r <= in_tvalid;
      end
      if (out_free) begin
        out_valid_r <= item_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      item_r <= in_tdata;
    end
    if (step) begin
      res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_TDATA_W-$bits(out_item_t)){1'b0}}, res_r};

endmodule

// ===== hw/rtl/hzc_checker.sv =====
`include "humidity_zone_classifier_assert.svh"

module hzc_checker
  import hzc_pkg::*;
(
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_tready,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata
);

  `HZC_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))
  `HZC_ASSERT_NOW(a_lock_floor, out_tvalid && out_tdata[2], out_tdata[1])
  `HZC_ASSERT_NOW(a_pad_zero, out_tvalid, out_tdata[7:3] == 5'd0)
  `HZC_ASSERT_RST(a_rst_empty, !out_tvalid && in_tready)

endmodule

bind humidity_zone_classifier hzc_checker u_hzc_checker (.*);
